// ===== hw/rtl/cmdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdf_pkg
// Shared types and constants of the contour message deframer.
// ----------------------------------------------------------------------------
package cmdf_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAMERA_ID_LIMIT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLAG_LIMIT          = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTOUR_COUNT_LIMIT = 2'd2;

    // configuration reset values
    localparam logic [15:0] CAMERA_ID_LIMIT_RESET     = 16'd100;
    localparam logic [4:0]  FLAG_LIMIT_RESET          = 5'd10;
    localparam logic [15:0] CONTOUR_COUNT_LIMIT_RESET = 16'd100;

    // largest usable flag limit
    localparam logic [4:0]  FLAG_LIMIT_MAX = 5'd16;

    // flag values that change the message layout
    localparam logic [3:0]  FLAG_THREE_GROUPS = 4'd2;
    localparam logic [3:0]  FLAG_TYPED_MAX    = 4'd3;

    // result queue depth
    localparam int OUT_DEPTH = 4;

    // record kinds
    typedef enum logic [2:0] {
        KIND_HEADER   = 3'd0,
        KIND_LABEL    = 3'd1,
        KIND_OUT_IMG  = 3'd2,
        KIND_ABOVE_VP = 3'd3,
        KIND_DONE     = 3'd4,
        KIND_ERROR    = 3'd5
    } rec_kind_t;

    // error codes
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_TRUNCATED = 3'd1,
        ERR_CAMERA_ID = 3'd2,
        ERR_FLAG      = 3'd3,
        ERR_COUNT     = 3'd4
    } err_code_t;

    // parser phases
    typedef enum logic [3:0] {
        PH_CAM    = 4'd0,
        PH_FLAG   = 4'd1,
        PH_COUNT  = 4'd2,
        PH_LABEL  = 4'd3,
        PH_NOUT   = 4'd4,
        PH_NABOVE = 4'd5,
        PH_NVR    = 4'd6,
        PH_PX     = 4'd7,
        PH_PY     = 4'd8,
        PH_PTYPE  = 4'd9
    } phase_t;

    // input byte request
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    // result record request
    typedef struct packed {
        rec_kind_t   record_kind;
        logic [31:0] word_a;
        logic [31:0] word_b;
        logic [63:0] word_c;
        err_code_t   error_code;
        logic        end_of_message;
    } out_item_t;

    // limit registers
    typedef struct packed {
        logic [15:0] camera_id_limit;
        logic [4:0]  flag_limit;
        logic [15:0] contour_count_limit;
    } cfg_t;

    // records produced by one byte, rec0 first
    typedef struct packed {
        logic [1:0] count;
        out_item_t  rec0;
        out_item_t  rec1;
    } push_t;

endpackage

// ===== hw/rtl/cmdf_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdf_parser
// Byte-wise field assembly and message parser; emits up to two records
// for each byte that it steps on.
// ----------------------------------------------------------------------------
module cmdf_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  cmdf_pkg::in_item_t  item,
    input  cmdf_pkg::cfg_t      cfg,
    output cmdf_pkg::push_t     push
);

    cmdf_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  idx_reg, idx_next;
    logic [63:0] shift_reg, shift_next;
    logic [3:0]  flag_reg, flag_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] y_reg, y_next;
    logic [31:0] label_reg, label_next;
    logic [15:0] contours_reg, contours_next;
    logic [31:0] cnt_out_reg, cnt_out_next;
    logic [31:0] cnt_above_reg, cnt_above_next;
    logic [31:0] cnt_disc_reg, cnt_disc_next;
    logic        fin_reg, fin_next;

    logic [63:0] fv;
    logic [31:0] w;
    logic [4:0]  flim;
    logic        field_end;
    logic        np_req;
    logic        ec_req;
    logic        pd_req;
    logic [63:0] pd_type;
    logic        r1_v;
    logic        r2_v;
    cmdf_pkg::out_item_t r1;
    cmdf_pkg::out_item_t r2;

    // build one record
    function automatic cmdf_pkg::out_item_t make_rec(
        input cmdf_pkg::rec_kind_t kind,
        input logic [31:0]         a,
        input logic [31:0]         b,
        input logic [63:0]         c,
        input cmdf_pkg::err_code_t err,
        input logic                eom
    );
        cmdf_pkg::out_item_t r;
        r.record_kind    = kind;
        r.word_a         = a;
        r.word_b         = b;
        r.word_c         = c;
        r.error_code     = err;
        r.end_of_message = eom;
        return r;
    endfunction

    // next state and records for the current byte
    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        shift_next     = shift_reg;
        flag_next      = flag_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        label_next     = label_reg;
        contours_next  = contours_reg;
        cnt_out_next   = cnt_out_reg;
        cnt_above_next = cnt_above_reg;
        cnt_disc_next  = cnt_disc_reg;
        fin_next       = fin_reg;
        np_req         = 1'b0;
        ec_req         = 1'b0;
        pd_req         = 1'b0;
        pd_type        = 64'd0;
        r1_v           = 1'b0;
        r2_v           = 1'b0;
        r1 = make_rec(cmdf_pkg::KIND_DONE, 32'd0, 32'd0, 64'd0, cmdf_pkg::ERR_NONE, 1'b1);
        r2 = make_rec(cmdf_pkg::KIND_DONE, 32'd0, 32'd0, 64'd0, cmdf_pkg::ERR_NONE, 1'b1);
        flim = (cfg.flag_limit > cmdf_pkg::FLAG_LIMIT_MAX) ? cmdf_pkg::FLAG_LIMIT_MAX
                                                           : cfg.flag_limit;

        // gather the byte into the field
        fv = shift_reg | (64'(item.data_byte) << {idx_reg, 3'b000});
        w  = fv[31:0];
        if (phase_reg == cmdf_pkg::PH_PTYPE)
            field_end = (idx_reg == 3'd7);
        else
            field_end = (idx_reg == 3'd3);

        if (!fin_reg)
        begin
            if (!field_end)
            begin
                idx_next   = idx_reg + 3'd1;
                shift_next = fv;
            end
            else
            begin
                idx_next   = 3'd0;
                shift_next = 64'd0;

                // completed field
                case (phase_reg)
                    cmdf_pkg::PH_CAM:
                    begin
                        if (w >= 32'(cfg.camera_id_limit))
                        begin
                            fin_next = 1'b1;
                            r1_v     = 1'b1;
                            r1 = make_rec(cmdf_pkg::KIND_ERROR, 32'd0, 32'd0, 64'd0,
                                          cmdf_pkg::ERR_CAMERA_ID, 1'b1);
                        end
                        else
                        begin
                            label_next = w;
                            phase_next = cmdf_pkg::PH_FLAG;
                        end
                    end
                    cmdf_pkg::PH_FLAG:
                    begin
                        if (w >= 32'(flim))
                        begin
                            fin_next = 1'b1;
                            r1_v     = 1'b1;
                            r1 = make_rec(cmdf_pkg::KIND_ERROR, 32'd0, 32'd0, 64'd0,
                                          cmdf_pkg::ERR_FLAG, 1'b1);
                        end
                        else
                        begin
                            flag_next  = w[3:0];
                            phase_next = cmdf_pkg::PH_COUNT;
                        end
                    end
                    cmdf_pkg::PH_COUNT:
                    begin
                        if (w >= 32'(cfg.contour_count_limit))
                        begin
                            fin_next = 1'b1;
                            r1_v     = 1'b1;
                            r1 = make_rec(cmdf_pkg::KIND_ERROR, 32'd0, 32'd0, 64'd0,
                                          cmdf_pkg::ERR_COUNT, 1'b1);
                        end
                        else
                        begin
                            r1_v = 1'b1;
                            r1 = make_rec(cmdf_pkg::KIND_HEADER, label_reg, 32'(flag_reg),
                                          64'(w), cmdf_pkg::ERR_NONE, 1'b0);
                            contours_next = w[15:0];
                            if (w[15:0] == 16'd0)
                            begin
                                fin_next = 1'b1;
                                r2_v     = 1'b1;
                            end
                            else
                            begin
                                phase_next = cmdf_pkg::PH_LABEL;
                            end
                        end
                    end
                    cmdf_pkg::PH_LABEL:
                    begin
                        label_next     = w;
                        r1_v           = 1'b1;
                        r1 = make_rec(cmdf_pkg::KIND_LABEL, w, 32'd0, 64'd0,
                                      cmdf_pkg::ERR_NONE, 1'b0);
                        cnt_out_next   = 32'd0;
                        cnt_above_next = 32'd0;
                        cnt_disc_next  = 32'd0;
                        if (flag_reg == 4'd0)
                            ec_req = 1'b1;
                        else
                            phase_next = cmdf_pkg::PH_NOUT;
                    end
                    cmdf_pkg::PH_NOUT:
                    begin
                        cnt_out_next = w;
                        phase_next   = cmdf_pkg::PH_NABOVE;
                    end
                    cmdf_pkg::PH_NABOVE:
                    begin
                        cnt_above_next = w;
                        if (flag_reg == cmdf_pkg::FLAG_THREE_GROUPS)
                            phase_next = cmdf_pkg::PH_NVR;
                        else
                            np_req = 1'b1;
                    end
                    cmdf_pkg::PH_NVR:
                    begin
                        cnt_disc_next = w;
                        np_req        = 1'b1;
                    end
                    cmdf_pkg::PH_PX:
                    begin
                        x_next     = w;
                        phase_next = cmdf_pkg::PH_PY;
                    end
                    cmdf_pkg::PH_PY:
                    begin
                        y_next = w;
                        if (flag_reg <= cmdf_pkg::FLAG_TYPED_MAX)
                            phase_next = cmdf_pkg::PH_PTYPE;
                        else
                            pd_req = 1'b1;
                    end
                    cmdf_pkg::PH_PTYPE:
                    begin
                        pd_req  = 1'b1;
                        pd_type = fv;
                    end
                    default:
                    begin
                        phase_next = cmdf_pkg::PH_CAM;
                    end
                endcase

                // one point finished: count it against its group
                if (pd_req)
                begin
                    np_req = 1'b1;
                    if (cnt_out_reg != 32'd0)
                    begin
                        cnt_out_next = cnt_out_reg - 32'd1;
                        r1_v         = 1'b1;
                        r1 = make_rec(cmdf_pkg::KIND_OUT_IMG, x_next, y_next, pd_type,
                                      cmdf_pkg::ERR_NONE, 1'b0);
                    end
                    else if (cnt_above_reg != 32'd0)
                    begin
                        cnt_above_next = cnt_above_reg - 32'd1;
                        r1_v           = 1'b1;
                        r1 = make_rec(cmdf_pkg::KIND_ABOVE_VP, x_next, y_next, pd_type,
                                      cmdf_pkg::ERR_NONE, 1'b0);
                    end
                    else if (cnt_disc_reg != 32'd0)
                    begin
                        cnt_disc_next = cnt_disc_reg - 32'd1;
                    end
                end

                // more points in this contour or close it
                if (np_req)
                begin
                    if (cnt_out_next != 32'd0 || cnt_above_next != 32'd0 ||
                        cnt_disc_next != 32'd0)
                        phase_next = cmdf_pkg::PH_PX;
                    else
                        ec_req = 1'b1;
                end

                // close contour, done after the last one
                if (ec_req)
                begin
                    contours_next = contours_reg - 16'd1;
                    if (contours_next == 16'd0)
                    begin
                        fin_next = 1'b1;
                        r2_v     = 1'b1;
                    end
                    else
                    begin
                        phase_next = cmdf_pkg::PH_LABEL;
                    end
                end
            end
        end

        // end of buffer: truncation check and rearm
        if (item.last_byte)
        begin
            if (!fin_next)
            begin
                r2_v = 1'b1;
                r2 = make_rec(cmdf_pkg::KIND_ERROR, 32'd0, 32'd0, 64'd0,
                              cmdf_pkg::ERR_TRUNCATED, 1'b1);
            end
            phase_next     = cmdf_pkg::PH_CAM;
            idx_next       = 3'd0;
            shift_next     = 64'd0;
            contours_next  = 16'd0;
            cnt_out_next   = 32'd0;
            cnt_above_next = 32'd0;
            cnt_disc_next  = 32'd0;
            fin_next       = 1'b0;
        end
    end

    // pack records in order
    always_comb
    begin
        push.rec0 = r1_v ? r1 : r2;
        push.rec1 = r2;
        if (step)
            push.count = {1'b0, r1_v} + {1'b0, r2_v};
        else
            push.count = 2'd0;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cmdf_pkg::PH_CAM;
            idx_reg       <= 3'd0;
            shift_reg     <= 64'd0;
            flag_reg      <= 4'd0;
            x_reg         <= 32'd0;
            y_reg         <= 32'd0;
            label_reg     <= 32'd0;
            contours_reg  <= 16'd0;
            cnt_out_reg   <= 32'd0;
            cnt_above_reg <= 32'd0;
            cnt_disc_reg  <= 32'd0;
            fin_reg       <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            shift_reg     <= shift_next;
            flag_reg      <= flag_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            label_reg     <= label_next;
            contours_reg  <= contours_next;
            cnt_out_reg   <= cnt_out_next;
            cnt_above_reg <= cnt_above_next;
            cnt_disc_reg  <= cnt_disc_next;
            fin_reg       <= fin_next;
        end
    end

endmodule

// ===== hw/rtl/cmdf_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmdf_out_fifo
// Result queue: takes zero, one or two records a cycle, hands out one.
// ----------------------------------------------------------------------------
module cmdf_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmdf_pkg::push_t      push,
    output logic                 room,
    output logic                 result_valid,
    input  logic                 result_ready,
    output cmdf_pkg::out_item_t  result
);

    localparam int PTR_W = $clog2(cmdf_pkg::OUT_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    cmdf_pkg::out_item_t mem [cmdf_pkg::OUT_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    // pointer and fill bookkeeping
    always_comb
    begin
        pop         = result_valid && result_ready;
        wr_ptr_next = wr_ptr_reg + PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + CNT_W'(push.count) - CNT_W'(pop);
    end

    assign room         = (count_reg <= CNT_W'(cmdf_pkg::OUT_DEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result       = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.rec0;
        if (push.count == 2'd2)
            mem[wr_ptr_reg + PTR_W'(1)] <= push.rec1;
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== hw/rtl/contour_message_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour_message_deframer
// Little-endian contour message parser that emits header, label, point,
// done and error records.
// ----------------------------------------------------------------------------
// One message byte is taken per cycle while the result queue has room: a byte
// is held in an input register, parsed once the queue has two free entries, and
// its records (up to two) are written into a four-entry result queue, so each
// record passes through the input register and the queue before it is offered
// on the result port. Records leave the queue one per cycle while result_ready
// is high; when a byte completes two records the queue absorbs the extra one,
// and item_ready drops only when the queue has fewer than two free entries.
// Limit registers are written through the cfg channel, which is always ready;
// writes to an index beyond the three limits are ignored.
module contour_message_deframer (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_ready,
    input  cmdf_pkg::in_item_t                    item,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output cmdf_pkg::out_item_t                   result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cmdf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [cmdf_pkg::CFG_DATA_W-1:0]       cfg_data
);

    cmdf_pkg::cfg_t     cfg_reg;
    cmdf_pkg::in_item_t stage_reg;
    logic               stage_valid_reg;
    logic               room;
    logic               advance;
    cmdf_pkg::push_t    push;

    // limit registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera_id_limit     <= cmdf_pkg::CAMERA_ID_LIMIT_RESET;
            cfg_reg.flag_limit          <= cmdf_pkg::FLAG_LIMIT_RESET;
            cfg_reg.contour_count_limit <= cmdf_pkg::CONTOUR_COUNT_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cmdf_pkg::CFG_CAMERA_ID_LIMIT:
                    cfg_reg.camera_id_limit <= cfg_data[15:0];
                cmdf_pkg::CFG_FLAG_LIMIT:
                    cfg_reg.flag_limit <= cfg_data[4:0];
                cmdf_pkg::CFG_CONTOUR_COUNT_LIMIT:
                    cfg_reg.contour_count_limit <= cfg_data[15:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // input stage
    assign advance    = stage_valid_reg && room;
    assign item_ready = !stage_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else if (item_ready)
            stage_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            stage_reg <= item;
    end

    // parser
    cmdf_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (stage_reg),
        .cfg   (cfg_reg),
        .push  (push)
    );

    // result queue
    cmdf_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

// ===== dv/contour_message_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contour_message_deframer_tb
// Self-checking bench for the contour message deframer. Messages are built
// byte by byte (well-formed, truncated, out of limit, trailing junk and
// noise), sent with random gaps and result stalls under several limit
// settings, and every record is compared against an in-bench parser model.
// ----------------------------------------------------------------------------
module contour_message_deframer_tb;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 8;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             item_valid = 1'b0;
    logic                             item_ready;
    cmdf_pkg::in_item_t               item = '0;
    logic                             result_valid;
    logic                             result_ready = 1'b0;
    cmdf_pkg::out_item_t              result;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [cmdf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [cmdf_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // shadow copy of the limit registers
    logic [15:0] lim_camera = cmdf_pkg::CAMERA_ID_LIMIT_RESET;
    logic [4:0]  lim_flag   = cmdf_pkg::FLAG_LIMIT_RESET;
    logic [15:0] lim_count  = cmdf_pkg::CONTOUR_COUNT_LIMIT_RESET;

    // parser model state
    cmdf_pkg::phase_t parse_at = cmdf_pkg::PH_CAM;
    logic [2:0]  byte_idx = '0;
    logic [63:0] frame_shift = '0;
    logic [3:0]  flag_held = '0;
    logic [31:0] x_held = '0;
    logic [31:0] y_held = '0;
    logic [31:0] label_held = '0;
    logic [15:0] contours_left = '0;
    logic [31:0] outside_left = '0;
    logic [31:0] vanish_left = '0;
    logic [31:0] pts_discard = '0;
    logic        msg_closed = 1'b0;

    cmdf_pkg::out_item_t expected_records[$];
    cmdf_pkg::in_item_t  pending_bytes[$];
    logic [7:0]  msg_bytes[$];
    int          queued_bytes = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // handshake bookkeeping
    logic        byte_taken = 1'b0;
    logic        result_taken = 1'b0;
    int          send_gap = 0;
    int          send_burst = 0;
    int          stall_left = 0;
    int          stall_burst = 0;

    contour_message_deframer uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------
    function automatic void push_record(cmdf_pkg::rec_kind_t kind, logic [31:0] a,
                                        logic [31:0] b, logic [63:0] c,
                                        cmdf_pkg::err_code_t err, logic eom);
        cmdf_pkg::out_item_t rec;
        rec.record_kind    = kind;
        rec.word_a         = a;
        rec.word_b         = b;
        rec.word_c         = c;
        rec.error_code     = err;
        rec.end_of_message = eom;
        expected_records.push_back(rec);
    endfunction

    function automatic void raise_error(cmdf_pkg::err_code_t code);
        msg_closed = 1'b1;
        push_record(cmdf_pkg::KIND_ERROR, '0, '0, '0, code, 1'b1);
    endfunction

    function automatic void close_message();
        msg_closed = 1'b1;
        push_record(cmdf_pkg::KIND_DONE, '0, '0, '0, cmdf_pkg::ERR_NONE, 1'b1);
    endfunction

    function automatic void end_contour();
        contours_left = contours_left - 16'd1;
        if (contours_left == 16'd0)
            close_message();
        else
            parse_at = cmdf_pkg::PH_LABEL;
    endfunction

    function automatic void next_points();
        if (outside_left != 0 || vanish_left != 0 || pts_discard != 0)
            parse_at = cmdf_pkg::PH_PX;
        else
            end_contour();
    endfunction

    // groups are drained in order; the discard group is never reported
    function automatic void point_done(logic [63:0] ptype);
        if (outside_left != 0)
        begin
            outside_left--;
            push_record(cmdf_pkg::KIND_OUT_IMG, x_held, y_held, ptype,
                        cmdf_pkg::ERR_NONE, 1'b0);
        end
        else if (vanish_left != 0)
        begin
            vanish_left--;
            push_record(cmdf_pkg::KIND_ABOVE_VP, x_held, y_held, ptype,
                        cmdf_pkg::ERR_NONE, 1'b0);
        end
        else if (pts_discard != 0)
        begin
            pts_discard--;
        end
        next_points();
    endfunction

    function automatic void deframe_byte(cmdf_pkg::in_item_t b);
        logic [63:0] v;
        logic [31:0] w;
        logic [4:0]  flim;
        int          len;
        if (!msg_closed)
        begin
            len = (parse_at == cmdf_pkg::PH_PTYPE) ? 8 : 4;
            frame_shift = frame_shift | (64'(b.data_byte) << (8 * byte_idx));
            if (byte_idx + 1 < len)
            begin
                byte_idx = byte_idx + 3'd1;
            end
            else
            begin
                v = frame_shift;
                w = v[31:0];
                byte_idx = '0;
                frame_shift = '0;
                flim = (lim_flag > cmdf_pkg::FLAG_LIMIT_MAX) ? cmdf_pkg::FLAG_LIMIT_MAX
                                                             : lim_flag;
                case (parse_at)
                    cmdf_pkg::PH_CAM:
                    begin
                        if (w >= lim_camera)
                            raise_error(cmdf_pkg::ERR_CAMERA_ID);
                        else
                        begin
                            label_held = w;
                            parse_at = cmdf_pkg::PH_FLAG;
                        end
                    end
                    cmdf_pkg::PH_FLAG:
                    begin
                        if (w >= flim)
                            raise_error(cmdf_pkg::ERR_FLAG);
                        else
                        begin
                            flag_held = w[3:0];
                            parse_at = cmdf_pkg::PH_COUNT;
                        end
                    end
                    cmdf_pkg::PH_COUNT:
                    begin
                        if (w >= lim_count)
                            raise_error(cmdf_pkg::ERR_COUNT);
                        else
                        begin
                            push_record(cmdf_pkg::KIND_HEADER, label_held, 32'(flag_held),
                                        64'(w), cmdf_pkg::ERR_NONE, 1'b0);
                            contours_left = w[15:0];
                            if (contours_left == 16'd0)
                                close_message();
                            else
                                parse_at = cmdf_pkg::PH_LABEL;
                        end
                    end
                    cmdf_pkg::PH_LABEL:
                    begin
                        label_held = w;
                        push_record(cmdf_pkg::KIND_LABEL, w, '0, '0, cmdf_pkg::ERR_NONE, 1'b0);
                        outside_left = '0;
                        vanish_left = '0;
                        pts_discard = '0;
                        if (flag_held == 4'd0)
                            end_contour();
                        else
                            parse_at = cmdf_pkg::PH_NOUT;
                    end
                    cmdf_pkg::PH_NOUT:
                    begin
                        outside_left = w;
                        parse_at = cmdf_pkg::PH_NABOVE;
                    end
                    cmdf_pkg::PH_NABOVE:
                    begin
                        vanish_left = w;
                        if (flag_held == cmdf_pkg::FLAG_THREE_GROUPS)
                            parse_at = cmdf_pkg::PH_NVR;
                        else
                            next_points();
                    end
                    cmdf_pkg::PH_NVR:
                    begin
                        pts_discard = w;
                        next_points();
                    end
                    cmdf_pkg::PH_PX:
                    begin
                        x_held = w;
                        parse_at = cmdf_pkg::PH_PY;
                    end
                    cmdf_pkg::PH_PY:
                    begin
                        y_held = w;
                        if (flag_held <= cmdf_pkg::FLAG_TYPED_MAX)
                            parse_at = cmdf_pkg::PH_PTYPE;
                        else
                            point_done('0);
                    end
                    cmdf_pkg::PH_PTYPE:
                        point_done(v);
                    default:
                        parse_at = cmdf_pkg::PH_CAM;
                endcase
            end
        end
        // end of buffer: flag truncation, then rearm for the next message
        if (b.last_byte)
        begin
            if (!msg_closed)
                raise_error(cmdf_pkg::ERR_TRUNCATED);
            parse_at = cmdf_pkg::PH_CAM;
            byte_idx = '0;
            frame_shift = '0;
            contours_left = '0;
            outside_left = '0;
            vanish_left = '0;
            pts_discard = '0;
            msg_closed = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap(ref int burst);
        int r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 8);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [31:0] pick_below(logic [31:0] lim);
        if (lim == 0)
            return $urandom;
        return $urandom_range(0, lim - 1);
    endfunction

    function automatic logic [31:0] bad_value(logic [31:0] lim);
        int r;
        r = $urandom_range(0, 3);
        if (r < 2)
            return lim + $urandom_range(0, 2);
        if (r == 2)
            return 32'hFFFF_FFFF;
        return $urandom | 32'h0001_0000;
    endfunction

    // mostly tiny groups, now and then a huge one that cuts the message short
    function automatic logic [31:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85)
            return $urandom_range(0, 2);
        if (r < 95)
            return 32'd3;
        return $urandom;
    endfunction

    function automatic void append_le(logic [63:0] v, int n);
        for (int k = 0; k < n; k++)
            msg_bytes.push_back(v[8*k +: 8]);
    endfunction

    function automatic void send_message();
        cmdf_pkg::in_item_t b;
        foreach (msg_bytes[i])
        begin
            b.data_byte = msg_bytes[i];
            b.last_byte = (i == msg_bytes.size() - 1);
            pending_bytes.push_back(b);
            queued_bytes++;
        end
    endfunction

    // keep: 0 whole message, >0 first keep bytes, <0 random cut
    task automatic queue_message(input logic [31:0] cam, input logic [31:0] flg,
                                 input logic [31:0] cnt, input int keep, input int tail);
        logic [31:0] grp [3];
        int          n_contours;
        int          n_points;
        msg_bytes.delete();
        append_le(cam, 4);
        append_le(flg, 4);
        append_le(cnt, 4);
        n_contours = (cnt > 4) ? 4 : int'(cnt);
        for (int c = 0; c < n_contours; c++)
        begin
            append_le($urandom, 4);
            if (flg != 0)
            begin
                n_points = 0;
                foreach (grp[g])
                begin
                    grp[g] = (g == 2 && flg != 2) ? 32'd0 : pick_count();
                    if (g < 2 || flg == 2)
                        append_le(grp[g], 4);
                    n_points += (grp[g] > 3) ? 3 : int'(grp[g]);
                end
                repeat (n_points)
                begin
                    append_le($urandom, 4);
                    append_le($urandom, 4);
                    if (flg <= 3)
                        append_le({$urandom, $urandom}, 8);
                end
            end
        end
        if (keep < 0 && msg_bytes.size() > 1)
            keep = $urandom_range(1, msg_bytes.size() - 1);
        if (keep > 0 && keep < msg_bytes.size())
            msg_bytes = msg_bytes[0:keep-1];
        repeat (tail)
            msg_bytes.push_back(8'($urandom));
        send_message();
    endtask

    task automatic queue_traffic(input int budget);
        int          stop_at;
        int          r;
        logic [31:0] flim;
        logic [31:0] cam;
        logic [31:0] flg;
        logic [31:0] cnt;
        stop_at = queued_bytes + budget;
        while (queued_bytes < stop_at)
        begin
            r = $urandom_range(0, 99);
            flim = (lim_flag > cmdf_pkg::FLAG_LIMIT_MAX) ? cmdf_pkg::FLAG_LIMIT_MAX
                                                         : lim_flag;
            cam = pick_below(lim_camera);
            flg = pick_below(flim);
            if ($urandom_range(0, 19) == 0)
                cnt = pick_below(lim_count);
            else
                cnt = pick_below((lim_count < 4) ? lim_count : 4);
            if (r < 60)
                queue_message(cam, flg, cnt, 0,
                              ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0);
            else if (r < 78)
                queue_message(cam, flg, cnt, -1, 0);
            else if (r < 84)
                queue_message(bad_value(lim_camera), flg, cnt, 0, 0);
            else if (r < 89)
                queue_message(cam, bad_value(flim), cnt, 0, 0);
            else if (r < 94)
                queue_message(cam, flg, bad_value(lim_count), 0, 0);
            else
            begin
                msg_bytes.delete();
                repeat ($urandom_range(1, 6))
                    msg_bytes.push_back(8'($urandom));
                send_message();
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_bytes.size() != 0 || item_valid || expected_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [cmdf_pkg::CFG_INDEX_W-1:0] idx,
                               input logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            cmdf_pkg::CFG_CAMERA_ID_LIMIT:     lim_camera = val;
            cmdf_pkg::CFG_FLAG_LIMIT:          lim_flag = val[4:0];
            cmdf_pkg::CFG_CONTOUR_COUNT_LIMIT: lim_count = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_limits(input logic [15:0] cam, input logic [15:0] flg,
                                input logic [15:0] cnt);
        write_limit(cmdf_pkg::CFG_CAMERA_ID_LIMIT, cam);
        write_limit(cmdf_pkg::CFG_FLAG_LIMIT, flg);
        write_limit(cmdf_pkg::CFG_CONTOUR_COUNT_LIMIT, cnt);
    endtask

    // ------------------------------------------------------------------------
    // byte request driver
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else if (!item_valid || byte_taken)
        begin
            if (send_gap > 0)
            begin
                item_valid <= 1'b0;
                send_gap = send_gap - 1;
            end
            else if (pending_bytes.size() != 0)
            begin
                item_valid <= 1'b1;
                item <= pending_bytes.pop_front();
                send_gap = pick_gap(send_burst);
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure
    always @(negedge clk)
    begin
        if (result_taken)
            stall_left = pick_gap(stall_burst);
        if (rst_n && stall_left == 0)
        begin
            result_ready <= 1'b1;
        end
        else
        begin
            result_ready <= 1'b0;
            if (stall_left > 0)
                stall_left = stall_left - 1;
        end
    end

    // ------------------------------------------------------------------------
    // prediction and record checking
    // ------------------------------------------------------------------------
    function automatic void check_field(string field, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h got %h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        cmdf_pkg::out_item_t want;
        byte_taken   <= item_valid && item_ready;
        result_taken <= result_valid && result_ready;
        if (rst_n)
        begin
            if (item_valid && item_ready)
                deframe_byte(item);
            if (result_valid && result_ready)
            begin
                if (expected_records.size() == 0)
                begin
                    $display("%0t: unexpected record expected none got %h", $time, result);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_records.pop_front();
                    check_field("record_kind", 64'(want.record_kind), 64'(result.record_kind));
                    check_field("word_a", 64'(want.word_a), 64'(result.word_a));
                    check_field("word_b", 64'(want.word_b), 64'(result.word_b));
                    check_field("word_c", want.word_c, result.word_c);
                    check_field("error_code", 64'(want.error_code), 64'(result.error_code));
                    check_field("end_of_message", 64'(want.end_of_message),
                                64'(result.end_of_message));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d records outstanding", $time,
                     expected_records.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: all-ones camera id, all-zero id with bad flag,
        // empty contour set at the limit edge, one-byte truncated message
        queue_message(32'hFFFF_FFFF, 32'd0, 32'd0, 4, 0);
        queue_message(32'd0, 32'hFFFF_FFFF, 32'd0, 8, 0);
        queue_message(32'd99, 32'd9, 32'd0, 0, 0);
        queue_message(32'd5, 32'd1, 32'd2, 1, 0);
        queue_traffic(190);
        wait_idle();

        // widest limits
        apply_limits(16'd65535, 16'd16, 16'd65535);
        queue_traffic(190);
        wait_idle();

        // tightest nonzero limits
        apply_limits(16'd1, 16'd1, 16'd1);
        queue_traffic(110);
        wait_idle();

        // flag limit above sixteen
        apply_limits(16'd7, 16'd20, 16'd3);
        queue_traffic(160);
        wait_idle();

        // zero limits reject everything
        apply_limits(16'd0, 16'd5, 16'd0);
        queue_traffic(40);
        wait_idle();

        apply_limits(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 16)),
                     16'($urandom_range(1, 65535)));
        queue_traffic(170);
        wait_idle();

        apply_limits(16'd100, 16'd4, 16'd6);
        queue_traffic(170);
        wait_idle();

        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_records.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== contour_message_deframer.f =====
hw/rtl/cmdf_pkg.sv
hw/rtl/cmdf_parser.sv
hw/rtl/cmdf_out_fifo.sv
hw/rtl/contour_message_deframer.sv
dv/contour_message_deframer_tb.sv
